@@ rtl/core/opd_pkg.sv @@
// opd_pkg: shared widths and the token flag type for the dedup cell chain
// no dependencies; imported by the cell, the top level and the checker
`default_nettype none

package opd_pkg;

    // fixed field widths of the stream items
    localparam int ELEM_W  = 32;
    localparam int COUNT_W = 7;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 40;
    localparam int TUSER_OUT_W = 2;

    // tuser bit positions on the result side
    localparam int TUSER_IS_FIRST   = 0;
    localparam int TUSER_OVERFLOWED = 1;

    // per-transaction status traveling down the chain
    typedef struct packed {
        logic last;    // final element of the array
        logic found;   // matched a stored value
        logic stored;  // claimed a free cell
    } t_tok_flags;

endpackage

`default_nettype wire

@@ rtl/core/opd_cell.sv @@
// opd_cell: one store entry of the dedup chain plus one pipeline stage
// depends on opd_pkg
`default_nettype none

module opd_cell
    import opd_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_valid,
    input  wire logic [ELEM_W-1:0] i_elem,
    input  wire t_tok_flags        i_flags,
    input  wire logic [CNT_W-1:0]  i_cnt,
    output logic                   o_valid,
    output logic [ELEM_W-1:0]      o_elem,
    output t_tok_flags             o_flags,
    output logic [CNT_W-1:0]       o_cnt
);

    logic [VALUE_WIDTH-1:0] w_key;
    logic                   r_occ;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_valid;
    logic [ELEM_W-1:0]      r_elem;
    t_tok_flags             r_flags;
    logic [CNT_W-1:0]       r_cnt;
    logic                   n_occ;
    logic                   w_hit;
    logic                   w_claim;
    logic                   w_occ_after;
    t_tok_flags             n_flags;

    // compare key is the element cut or zero-extended to the store width
    if (VALUE_WIDTH <= ELEM_W) begin : g_key_cut
        assign w_key = i_elem[VALUE_WIDTH-1:0];
    end else begin : g_key_ext
        assign w_key = {{(VALUE_WIDTH-ELEM_W){1'b0}}, i_elem};
    end

    always_comb begin
        w_hit       = i_valid && r_occ && (r_val == w_key);
        w_claim     = i_valid && !r_occ && !i_flags.found && !i_flags.stored;
        w_occ_after = r_occ || w_claim;
        n_flags        = i_flags;
        n_flags.found  = i_flags.found || w_hit;
        n_flags.stored = i_flags.stored || w_claim;
        // last element empties the store behind it
        if (i_valid && i_flags.last) begin
            n_occ = 1'b0;
        end else begin
            n_occ = w_occ_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_occ   <= n_occ;
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_claim) begin
                r_val <= w_key;
            end
            r_elem  <= i_elem;
            r_flags <= n_flags;
            r_cnt   <= i_cnt + {{(CNT_W-1){1'b0}}, w_occ_after};
        end
    end

    assign o_valid = r_valid;
    assign o_elem  = r_elem;
    assign o_flags = r_flags;
    assign o_cnt   = r_cnt;

endmodule

`default_nettype wire

@@ rtl/core/order_preserving_dedup_unit.sv @@
// order_preserving_dedup_unit: keep-first stream deduplication on a chain of store cells
// depends on opd_pkg and opd_cell
`default_nettype none

// Each array element enters as one transaction and walks a row of STORE_DEPTH
// cells, one cell per clock unless the row holds. Each cell holds at most one
// distinct value of the current array: the element is compared against it,
// and the first free cell that an unmatched element reaches takes it. Because
// elements move in order, every element sees exactly the values stored by the
// elements ahead of it. The element flagged tlast empties each cell as it
// leaves it. A new element is accepted every clock unless the row holds; its
// result leaves the last cell, with a delay set by the length of the cell row.
// When the result port stalls the whole row holds, so s_axis_tready follows
// m_axis_tready whenever a result is waiting. A result marked overflowed means
// a new value found all cells full; it stays marked until the array ends.
module order_preserving_dedup_unit
    import opd_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // element stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [31:0] element
    input  wire logic                   s_axis_tlast,  // end_of_array
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,  // [31:0] value, [38:32] distinct_count
    output logic [TUSER_OUT_W-1:0]      m_axis_tuser,  // [0] is_first, [1] overflowed
    output logic                        m_axis_tlast   // final_element
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    // chain links: index 0 is the input, index STORE_DEPTH the last cell
    logic             w_valid [STORE_DEPTH+1];
    logic [ELEM_W-1:0] w_elem [STORE_DEPTH+1];
    t_tok_flags       w_flags [STORE_DEPTH+1];
    logic [CNT_W-1:0] w_cnt   [STORE_DEPTH+1];

    logic             w_adv;
    logic             r_ovf_seen;
    logic             w_ovf_now;
    logic             w_out_ovf;
    logic [COUNT_W-1:0] w_count_out;
    t_tok_flags       w_in_flags;

    // whole row moves unless a finished result is waiting
    assign w_adv         = !w_valid[STORE_DEPTH] || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_comb begin
        w_in_flags        = '0;
        w_in_flags.last   = s_axis_tlast;
    end

    assign w_valid[0] = s_axis_tvalid;
    assign w_elem[0]  = s_axis_tdata[ELEM_W-1:0];
    assign w_flags[0] = w_in_flags;
    assign w_cnt[0]   = '0;

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        opd_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_elem  (w_elem[g]),
            .i_flags (w_flags[g]),
            .i_cnt   (w_cnt[g]),
            .o_valid (w_valid[g+1]),
            .o_elem  (w_elem[g+1]),
            .o_flags (w_flags[g+1]),
            .o_cnt   (w_cnt[g+1])
        );
    end

    // unmatched and no free cell: store was full
    assign w_ovf_now = !w_flags[STORE_DEPTH].found && !w_flags[STORE_DEPTH].stored;
    assign w_out_ovf = r_ovf_seen || w_ovf_now;

    // sticky overflow for the array, updated as results leave in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_seen <= 1'b0;
        end else if (w_valid[STORE_DEPTH] && m_axis_tready) begin
            if (w_flags[STORE_DEPTH].last) begin
                r_ovf_seen <= 1'b0;
            end else begin
                r_ovf_seen <= w_out_ovf;
            end
        end
    end

    // reported count is the low bits of the occupancy, zero-extended when narrower
    if (CNT_W >= COUNT_W) begin : g_cnt_cut
        assign w_count_out = w_cnt[STORE_DEPTH][COUNT_W-1:0];
    end else begin : g_cnt_ext
        assign w_count_out = {{(COUNT_W-CNT_W){1'b0}}, w_cnt[STORE_DEPTH]};
    end

    assign m_axis_tvalid = w_valid[STORE_DEPTH];
    assign m_axis_tdata  = {{(TDATA_OUT_W-ELEM_W-COUNT_W){1'b0}}, w_count_out,
                            w_elem[STORE_DEPTH]};
    assign m_axis_tuser[TUSER_IS_FIRST]   = !w_flags[STORE_DEPTH].found;
    assign m_axis_tuser[TUSER_OVERFLOWED] = w_out_ovf;
    assign m_axis_tlast  = w_flags[STORE_DEPTH].last;

endmodule

`default_nettype wire

@@ rtl/core/opd_checker.sv @@
// opd_checker: port-level assertions for order_preserving_dedup_unit, bound to the top level
// depends on opd_pkg
`default_nettype none

module opd_checker
    import opd_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input wire logic [TUSER_OUT_W-1:0] m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    localparam logic [COUNT_W-1:0] DEPTH_LOW = COUNT_W'(STORE_DEPTH % 128);
    localparam bit COUNT_WRAPS = (STORE_DEPTH >= 128);

    logic [COUNT_W-1:0] w_count;
    assign w_count = m_axis_tdata[ELEM_W+COUNT_W-1:ELEM_W];

    // no result straight out of reset
    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // every result counts at least its own value, unless the count field wraps
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count != '0) || COUNT_WRAPS)
        else $error("distinct count is zero");

    // once overflowed the store stays full for the array
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_OVERFLOWED] |-> w_count == DEPTH_LOW)
        else $error("overflow flagged with store not full");

endmodule

bind order_preserving_dedup_unit opd_checker #(.STORE_DEPTH(STORE_DEPTH)) u_opd_checker (.*);

`default_nettype wire
